>>> src/vlpd_pkg.sv
// ----------------------------------------------------------------------------
// vlpd_pkg
// shared types and constants of the varint length packet deframer
// ----------------------------------------------------------------------------
`default_nettype none

package vlpd_pkg;

  localparam int unsigned MaxVarintBytesDef = 5;
  localparam int unsigned ValueW            = 32;

  typedef enum logic [1:0] {
    ST_PAYLOAD   = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_TOO_LONG  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              last;
    logic              compressed;
    logic [ValueW-1:0] uncompressed_length;
    status_e           status;
  } result_t;

endpackage

`default_nettype wire

>>> src/vlpd_intf.sv
// ----------------------------------------------------------------------------
// vlpd_intf
// valid/ready channels for received bytes and deframed result words
// ----------------------------------------------------------------------------
`default_nettype none

interface vlpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface vlpd_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last;
  logic        compressed;
  logic [31:0] uncompressed_length;
  logic [1:0]  status;

  modport source (output valid, output out_byte, output last, output compressed,
                  output uncompressed_length, output status, input ready);
  modport sink   (input valid, input out_byte, input last, input compressed,
                  input uncompressed_length, input status, output ready);
endinterface

`default_nettype wire

>>> src/vlpd_in_stage.sv
// ----------------------------------------------------------------------------
// vlpd_in_stage
// input register holding the byte under decode
// ----------------------------------------------------------------------------
`default_nettype none

module vlpd_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire logic [7:0] byte_i,
  output logic            ready_o,
  input  wire logic       take_i,
  output logic            valid_o,
  output logic [7:0]      byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

>>> src/vlpd_core.sv
// ----------------------------------------------------------------------------
// vlpd_core
// deframing state and single-step update for one byte
// ----------------------------------------------------------------------------
`default_nettype none

module vlpd_core
  import vlpd_pkg::*;
#(
  parameter int unsigned MAX_VARINT_BYTES = MaxVarintBytesDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       comp_en_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       step_i,
  output logic            res_valid_o,
  output result_t         res_o
);

  localparam int unsigned CntW = $clog2(MAX_VARINT_BYTES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_VARINT_BYTES);

  localparam logic [1:0] PH_LEN  = 2'd0;
  localparam logic [1:0] PH_ULEN = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  logic [1:0]        phase_q, phase_d;
  logic [ValueW-1:0] value_q, value_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ValueW-1:0] remain_q, remain_d;
  logic [ValueW-1:0] ulen_q, ulen_d;
  logic              flag_q, flag_d;

  logic [ValueW-1:0] shifted;
  logic [ValueW-1:0] value_new;
  logic [CntW-1:0]   cnt_new;
  logic              vi_done;
  logic              vi_long;
  logic [ValueW-1:0] used;
  logic              ulen_nz;

  always_comb begin
    shifted = '0;
    for (int i = 0; i < MAX_VARINT_BYTES; i++) begin
      if (cnt_q == CntW'(i) && (7 * i) < ValueW) begin
        shifted = ValueW'({25'd0, byte_i[6:0]}) << (7 * i);
      end
    end
  end

  assign value_new = value_q | shifted;
  assign cnt_new   = cnt_q + 1'b1;
  assign vi_done   = !byte_i[7];
  assign vi_long   = byte_i[7] && (cnt_new >= MaxCnt);
  assign used      = ValueW'(cnt_new);
  assign ulen_nz   = (value_new != '0);

  always_comb begin
    phase_d     = phase_q;
    value_d     = value_q;
    cnt_d       = cnt_q;
    remain_d    = remain_q;
    ulen_d      = ulen_q;
    flag_d      = flag_q;
    res_valid_o = 1'b0;
    res_o       = '{out_byte: 8'd0, last: 1'b1, compressed: 1'b0,
                    uncompressed_length: '0, status: ST_PAYLOAD};

    case (phase_q)
      PH_DATA: begin
        res_valid_o      = 1'b1;
        res_o.out_byte   = byte_i;
        res_o.last       = (remain_q <= ValueW'(1));
        res_o.compressed = flag_q;
        res_o.uncompressed_length = ulen_q;
        remain_d = remain_q - 1'b1;
        if (remain_q <= ValueW'(1)) begin
          phase_d = PH_LEN;
        end
      end
      PH_ULEN: begin
        value_d = value_new;
        cnt_d   = cnt_new;
        if (vi_done) begin
          phase_d = PH_LEN;
          value_d = '0;
          cnt_d   = '0;
          ulen_d  = value_new;
          flag_d  = ulen_nz;
          res_o.compressed          = ulen_nz;
          res_o.uncompressed_length = value_new;
          if (used > remain_q) begin
            res_valid_o  = 1'b1;
            res_o.status = ST_UNDERFLOW;
          end else begin
            remain_d = remain_q - used;
            if (remain_q == used) begin
              res_valid_o  = 1'b1;
              res_o.status = ST_EMPTY;
            end else begin
              phase_d = PH_DATA;
            end
          end
        end else if (vi_long) begin
          phase_d      = PH_LEN;
          value_d      = '0;
          cnt_d        = '0;
          res_valid_o  = 1'b1;
          res_o.status = ST_TOO_LONG;
        end
      end
      default: begin
        phase_d = PH_LEN;
        value_d = value_new;
        cnt_d   = cnt_new;
        if (vi_done) begin
          value_d  = '0;
          cnt_d    = '0;
          remain_d = value_new;
          ulen_d   = '0;
          flag_d   = 1'b0;
          if (!ulen_nz) begin
            res_valid_o  = 1'b1;
            res_o.status = ST_EMPTY;
          end else begin
            phase_d = comp_en_i ? PH_ULEN : PH_DATA;
          end
        end else if (vi_long) begin
          value_d      = '0;
          cnt_d        = '0;
          res_valid_o  = 1'b1;
          res_o.status = ST_TOO_LONG;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LEN;
      value_q  <= '0;
      cnt_q    <= '0;
      remain_q <= '0;
      ulen_q   <= '0;
      flag_q   <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      value_q  <= value_d;
      cnt_q    <= cnt_d;
      remain_q <= remain_d;
      ulen_q   <= ulen_d;
      flag_q   <= flag_d;
    end
  end

endmodule

`default_nettype wire

>>> src/vlpd_out_stage.sv
// ----------------------------------------------------------------------------
// vlpd_out_stage
// result register toward the downstream word channel
// ----------------------------------------------------------------------------
`default_nettype none

module vlpd_out_stage
  import vlpd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire result_t  data_i,
  output logic          space_o,
  output logic          valid_o,
  input  wire logic     ready_i,
  output result_t       data_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign space_o = !valid_q || ready_i;
  assign valid_d = push_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

>>> src/varint_length_packet_deframer.sv
// an accepted byte is held in the input stage, its result word in the output stage
// throughput: one byte per cycle while the output stage has space for a result word
// header bytes produce no word unless they end an empty packet or an error
// rst_ni clears the deframing state, compression enable and both stage valids
// ----------------------------------------------------------------------------
// varint_length_packet_deframer
// splits a byte stream into varint length prefixed packets
// ----------------------------------------------------------------------------
`default_nettype none

module varint_length_packet_deframer
  import vlpd_pkg::*;
#(
  parameter int unsigned MAX_VARINT_BYTES = MaxVarintBytesDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic      cfg_wdata_i,
  vlpd_byte_if.sink      rx_i,
  vlpd_result_if.source  tx_o
);

  logic       comp_en_q;
  logic       st_valid;
  logic [7:0] st_byte;
  logic       step;
  logic       res_valid;
  result_t    res;
  logic       out_space;
  result_t    out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      comp_en_q <= cfg_wdata_i;
    end
  end

  assign step = st_valid && (!res_valid || out_space);

  vlpd_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rx_i.valid),
    .byte_i  (rx_i.in_byte),
    .ready_o (rx_i.ready),
    .take_i  (step),
    .valid_o (st_valid),
    .byte_o  (st_byte)
  );

  vlpd_core #(
    .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .comp_en_i   (comp_en_q),
    .byte_i      (st_byte),
    .step_i      (step),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  vlpd_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step && res_valid),
    .data_i  (res),
    .space_o (out_space),
    .valid_o (tx_o.valid),
    .ready_i (tx_o.ready),
    .data_o  (out_data)
  );

  assign tx_o.out_byte            = out_data.out_byte;
  assign tx_o.last                = out_data.last;
  assign tx_o.compressed          = out_data.compressed;
  assign tx_o.uncompressed_length = out_data.uncompressed_length;
  assign tx_o.status              = out_data.status;

endmodule

`default_nettype wire

>>> src/vlpd_checker.sv
// ----------------------------------------------------------------------------
// vlpd_checker
// port-level checks on the deframer result words
// ----------------------------------------------------------------------------
`default_nettype none

module vlpd_checker
  import vlpd_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        tx_valid_i,
  input wire logic        tx_ready_i,
  input wire logic [7:0]  tx_byte_i,
  input wire logic        tx_last_i,
  input wire logic        tx_comp_i,
  input wire logic [31:0] tx_ulen_i,
  input wire logic [1:0]  tx_status_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_i && !tx_ready_i |=> tx_valid_i && $stable(tx_byte_i) && $stable(tx_last_i)
      && $stable(tx_ulen_i) && $stable(tx_status_i))
    else $error("stalled word changed");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_i && tx_status_i != ST_PAYLOAD |-> tx_last_i && tx_byte_i == 8'd0)
    else $error("status word not last or carries a byte");

  a_too_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_i && tx_status_i == ST_TOO_LONG |-> !tx_comp_i && tx_ulen_i == 32'd0)
    else $error("too long word carries length");

  a_comp_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_i |-> tx_comp_i == (tx_ulen_i != 32'd0))
    else $error("compressed flag disagrees with length");

endmodule

bind varint_length_packet_deframer vlpd_checker u_vlpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .tx_valid_i  (tx_o.valid),
  .tx_ready_i  (tx_o.ready),
  .tx_byte_i   (tx_o.out_byte),
  .tx_last_i   (tx_o.last),
  .tx_comp_i   (tx_o.compressed),
  .tx_ulen_i   (tx_o.uncompressed_length),
  .tx_status_i (tx_o.status)
);

`default_nettype wire
